FILE: src/bdq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
package bdq_pkg;

   localparam int WORD_W = 32;
   localparam int CAP_W  = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef logic [1:0] req_kind_type;
   typedef logic [1:0] status_type;

   // request codes
   localparam req_kind_type REQ_PUSH_FRONT = 2'd0;
   localparam req_kind_type REQ_PUSH_BACK  = 2'd1;
   localparam req_kind_type REQ_POP_FRONT  = 2'd2;
   localparam req_kind_type REQ_POP_BACK   = 2'd3;

   // status codes
   localparam status_type ST_PUSHED = 2'd0;
   localparam status_type ST_POPPED = 2'd1;
   localparam status_type ST_FULL   = 2'd2;
   localparam status_type ST_EMPTY  = 2'd3;

   // per-request controls from the pointer unit
   typedef struct packed {
      status_type status;
      logic       wr_en;
      logic       rd_en;
   } ctl_type;

endpackage

FILE: src/bdq_ram.sv
// Simple dual-port word store with a registered read port.
module bdq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bdq_ptr.sv
// Front pointer and occupancy tracking; decides status and store access per request.
module bdq_ptr #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  bdq_pkg::req_kind_type       req_type,
   input  logic [bdq_pkg::CAP_W-1:0]   capacity,
   output bdq_pkg::ctl_type            ctl,
   output logic [$clog2(DEPTH)-1:0]    addr
);

   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(2 * DEPTH);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   logic [AW-1:0] front_ptr_ff, front_ptr_in;
   logic [CW-1:0] occ_ff, occ_in;

   logic [LW-1:0] limit;
   logic          full, empty;
   logic [AW-1:0] front_dec, front_inc, back_wr, back_rd;
   logic [SW-1:0] sum_wr, sum_rd;
   status_type    status;
   logic          wr_en, rd_en;

   // effective limit saturates at the store depth
   always_comb begin
      if (LW'(capacity) > LW'(DEPTH)) begin
         limit = LW'(DEPTH);
      end else begin
         limit = LW'(capacity);
      end
   end

   assign full  = LW'(occ_ff) >= limit;
   assign empty = (occ_ff == '0);

   // circular index arithmetic
   always_comb begin
      sum_wr = SW'(front_ptr_ff) + SW'(occ_ff);
      sum_rd = SW'(front_ptr_ff) + SW'(occ_ff) - SW'(1);
      if (sum_wr >= SW'(DEPTH)) begin
         back_wr = AW'(sum_wr - SW'(DEPTH));
      end else begin
         back_wr = AW'(sum_wr);
      end
      if (sum_rd >= SW'(DEPTH)) begin
         back_rd = AW'(sum_rd - SW'(DEPTH));
      end else begin
         back_rd = AW'(sum_rd);
      end
      if (front_ptr_ff == '0) begin
         front_dec = AW'(DEPTH - 1);
      end else begin
         front_dec = front_ptr_ff - AW'(1);
      end
      if (front_ptr_ff == AW'(DEPTH - 1)) begin
         front_inc = '0;
      end else begin
         front_inc = front_ptr_ff + AW'(1);
      end
   end

   // request decode and state update
   always_comb begin
      front_ptr_in = front_ptr_ff;
      occ_in       = occ_ff;
      status       = ST_EMPTY;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      addr         = front_ptr_ff;
      case (req_type)
         REQ_PUSH_FRONT: begin
            addr = front_dec;
            if (full) begin
               status = ST_FULL;
            end else begin
               status       = ST_PUSHED;
               wr_en        = 1'b1;
               front_ptr_in = front_dec;
               occ_in       = occ_ff + CW'(1);
            end
         end
         REQ_PUSH_BACK: begin
            addr = back_wr;
            if (full) begin
               status = ST_FULL;
            end else begin
               status = ST_PUSHED;
               wr_en  = 1'b1;
               occ_in = occ_ff + CW'(1);
            end
         end
         REQ_POP_FRONT: begin
            addr = front_ptr_ff;
            if (!empty) begin
               status       = ST_POPPED;
               rd_en        = 1'b1;
               front_ptr_in = front_inc;
               occ_in       = occ_ff - CW'(1);
            end
         end
         REQ_POP_BACK: begin
            addr = back_rd;
            if (!empty) begin
               status = ST_POPPED;
               rd_en  = 1'b1;
               occ_in = occ_ff - CW'(1);
            end
         end
         default: begin
            status = ST_EMPTY;
         end
      endcase
   end

   assign ctl.status = status;
   assign ctl.wr_en  = accept && wr_en;
   assign ctl.rd_en  = accept && rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ptr_ff <= '0;
         occ_ff       <= '0;
      end else if (accept) begin
         front_ptr_ff <= front_ptr_in;
         occ_ff       <= occ_in;
      end
   end

   // occupancy and pointer stay inside the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("occupancy above depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ptr_ff <= AW'(DEPTH - 1))
      else $error("front pointer outside store");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (accept && full && !req_type[1]) |=> $stable(occ_ff))
      else $error("rejected push changed occupancy");

endmodule

FILE: src/bounded_deque.sv
// Top level of the bounded double-ended queue: capacity register, store, result stages.
//
// A bounded double-ended queue of signed 32-bit words held in a DEPTH-word
// circular store. One request (push or pop at either end) is taken per cycle
// while req_stall is low. The registered store read and the pending stage
// load at the transfer edge; the output register then loads from them when
// it is free, and the result is presented from there. A pending stage
// in front of the output register lets a new request be taken while a result
// waits; req_stall rises only when both stages are full and rsp_stall is high.
// The capacity register (reset 16) limits how many words are held; values
// above DEPTH act as DEPTH and zero rejects every push. No clearing is needed
// after reset: only words written by a push are ever read back.
module bounded_deque #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bdq_pkg::req_kind_type       req_type,
   input  logic signed [31:0]          req_value,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bdq_pkg::status_type         rsp_status,
   output logic signed [31:0]          rsp_out_value,
   // capacity register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bdq_pkg::CAP_W-1:0]   csr_capacity
);

   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [CAP_W-1:0]  capacity_ff;
   logic              req_acc;
   ctl_type           ctl;
   logic [AW-1:0]     addr;
   logic [WORD_W-1:0] rd_data;

   logic              p_valid_ff, p_valid_in;
   status_type        p_status_ff;
   logic [WORD_W-1:0] p_value_ff;
   logic              p_from_mem_ff;
   logic              move;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;

   // capacity register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_capacity;
      end
   end

   // request transfer
   assign move      = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = p_valid_ff && !move;
   assign req_acc   = req_valid && !req_stall;

   bdq_ptr #(.DEPTH(DEPTH)) u_ptr (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_acc),
      .req_type (req_type),
      .capacity (capacity_ff),
      .ctl      (ctl),
      .addr     (addr)
   );

   bdq_ram #(.DEPTH(DEPTH), .WIDTH(WORD_W)) u_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (addr),
      .wr_data (req_value),
      .rd_en   (ctl.rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // pending stage: waits for the store read
   always_comb begin
      if (req_acc) begin
         p_valid_in = 1'b1;
      end else if (move) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         p_status_ff   <= ctl.status;
         p_from_mem_ff <= ctl.rd_en;
         p_value_ff    <= ctl.wr_en ? req_value : '0;
      end
   end

   // output register
   assign rsp_value_in = p_from_mem_ff ? rd_data : p_value_ff;

   always_comb begin
      if (move) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_status_ff <= p_status_ff;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;

   // a taken request always lands in the pending stage
   a_acc_pending: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> p_valid_ff)
      else $error("accepted request lost");

   // stall only when both result stages hold data
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (p_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("stall without full result stages");

   // rejected requests report a zero word
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY))
         |-> (rsp_out_value == '0))
      else $error("rejected request carries a word");

endmodule
